FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

FILE: sv/psdf_pkg.sv
// Package with the types, codes and reset constants of the sequence dedup filter.
package psdf_pkg;

  // Default number of table cells.
  localparam int unsigned DEF_TABLE_DEPTH = 64;

  // Field widths.
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned S_DATA_W = 88;
  localparam int unsigned M_DATA_W = 8;

  // Register reset values.
  localparam logic [ADDR_W-1:0] RST_OWN_ADDRESS   = '0;
  localparam logic [SEQ_W-1:0]  RST_SEQ_WINDOW    = 8'd10;
  localparam logic [TIME_W-1:0] RST_TIMEOUT_TICKS = 48'd1000000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ADDRESS   = 2'd0,
    REG_SEQ_WINDOW    = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } psdf_reg_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_KNOWN     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_OWN       = 3'd3,
    ST_FULL      = 3'd4
  } psdf_status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_GATHER,
    S_DECIDE
  } psdf_state_t;

  // One table entry, also the query that is broadcast to the cells.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] tstamp;
  } psdf_entry_t;

  // Stored sequence and time of a matching cell, zero when the cell misses.
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] tstamp;
  } psdf_hitdata_t;

  // Commands from the sequencer to every cell.
  typedef struct packed {
    logic lookup;
    logic shift;
    logic update;
  } psdf_ctl_t;

endpackage

FILE: sv/psdf_cell.sv
// One table cell: holds an entry, matches the query and takes its left neighbor on insert.
module psdf_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   entry_valid,
  input  psdf_pkg::psdf_ctl_t    ctl,
  input  psdf_pkg::psdf_entry_t  query,
  input  psdf_pkg::psdf_entry_t  left_entry,
  output psdf_pkg::psdf_entry_t  entry,
  output logic                   hit,
  output psdf_pkg::psdf_hitdata_t hit_data
);
  import psdf_pkg::*;

  logic match;

  assign match = entry_valid && (entry.addr == query.addr);

  // Entry storage: shift in from the left on insert, refresh on a hit update.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry <= left_entry;
    end else if (ctl.update && hit) begin
      entry.seq    <= query.seq;
      entry.tstamp <= query.tstamp;
    end
  end

  // Match flag, held until the sequencer issues the write for this item.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.lookup) begin
      hit <= match;
    end
  end

  // Masked copy of the stored fields so the row can be merged by a plain OR.
  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      hit_data <= match ? psdf_hitdata_t'{seq: entry.seq, tstamp: entry.tstamp} : '0;
    end
  end

endmodule

FILE: sv/psdf_decide.sv
// Decision unit: classifies a packet from the lookup result and the registers.
module psdf_decide (
  input  logic [psdf_pkg::ADDR_W-1:0] own_address,
  input  logic [psdf_pkg::SEQ_W-1:0]  seq_window,
  input  logic [psdf_pkg::TIME_W-1:0] timeout_ticks,
  input  psdf_pkg::psdf_entry_t       query,
  input  logic                        found,
  input  psdf_pkg::psdf_hitdata_t     found_data,
  input  logic                        table_full,
  output logic                        is_new,
  output psdf_pkg::psdf_status_t      status,
  output logic                        do_update,
  output logic                        do_insert
);
  import psdf_pkg::*;

  logic [TIME_W-1:0] age;
  logic [SEQ_W-1:0]  advance;
  logic              timed_out;
  logic              in_window;

  // Age wraps with the clock; an advance of zero stands for a full lap.
  assign age       = query.tstamp - found_data.tstamp;
  assign advance   = query.seq - found_data.seq;
  assign timed_out = age >= timeout_ticks;
  assign in_window = (advance != '0) && (advance < seq_window);

  always_comb begin
    is_new    = 1'b0;
    status    = ST_DUPLICATE;
    do_update = 1'b0;
    do_insert = 1'b0;
    priority if (query.addr == own_address) begin
      status = ST_OWN;
    end else if (found) begin
      if (timed_out || in_window) begin
        is_new    = 1'b1;
        status    = ST_KNOWN;
        do_update = 1'b1;
      end
    end else if (!table_full) begin
      is_new    = 1'b1;
      status    = ST_INSERTED;
      do_insert = 1'b1;
    end else begin
      is_new = 1'b1;
      status = ST_FULL;
    end
  end

endmodule

FILE: sv/per_source_sequence_dedup_filter.sv
// Top level of the per-source sequence number duplicate filter.
//
// Each input beat carries a packet's origin address, 8-bit sequence number and current
// time; one output beat per input says whether the packet is new and why. The source
// table is a row of TABLE_DEPTH cells; a new source enters at cell 0 and every valid
// entry moves one cell to the right, so cells below the entry count are the valid ones.
// An accepted beat goes through the lookup, gather and decide states: in lookup all cells
// compare the address, in gather the matching cell's fields are merged, and in decide the
// decision unit checks age and sequence advance and issues the table write, the next beat
// being accepted in the cycle after that. A result that is not taken holds the decision
// step, so a new beat is accepted only after the current one is decided. Table entries are
// not cleared at reset; the entry count alone marks them valid. Configuration registers
// must be written only while no beat is in flight; the block itself does not enforce this.
module per_source_sequence_dedup_filter #(
  parameter int unsigned TABLE_DEPTH = psdf_pkg::DEF_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [psdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psdf_pkg::CFG_W-1:0]     cfg_wdata,
  // Input stream.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // origin_address [31:0], sequence_req [39:32], now_time [87:40]
  input  logic [psdf_pkg::S_DATA_W-1:0]  s_tdata,
  // Output stream.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // is_new [0], status [3:1], zero [7:4]
  output logic [psdf_pkg::M_DATA_W-1:0]  m_tdata
);
  import psdf_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  psdf_state_t state, state_next;

  logic [ADDR_W-1:0] own_address;
  logic [SEQ_W-1:0]  seq_window;
  logic [TIME_W-1:0] timeout_ticks;

  logic [CNT_W-1:0]  entry_count;
  psdf_entry_t       query;
  psdf_ctl_t         ctl;

  psdf_entry_t       cell_entry [TABLE_DEPTH];
  logic              cell_hit   [TABLE_DEPTH];
  psdf_hitdata_t     cell_data  [TABLE_DEPTH];
  logic              cell_valid [TABLE_DEPTH];

  logic              merge_found;
  psdf_hitdata_t     merge_data;
  logic              found;
  psdf_hitdata_t     found_data;

  logic              dec_is_new;
  psdf_status_t      dec_status;
  logic              dec_update;
  logic              dec_insert;
  logic              table_full;
  logic              out_free;
  logic              out_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address   <= RST_OWN_ADDRESS;
      seq_window    <= RST_SEQ_WINDOW;
      timeout_ticks <= RST_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ADDRESS:   own_address   <= cfg_wdata[ADDR_W-1:0];
        REG_SEQ_WINDOW:    seq_window    <= cfg_wdata[SEQ_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Query register, loaded on each accepted input beat.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      query.addr   <= s_tdata[ADDR_W-1:0];
      query.seq    <= s_tdata[ADDR_W +: SEQ_W];
      query.tstamp <= s_tdata[ADDR_W+SEQ_W +: TIME_W];
    end
  end

  // Row of cells; cell 0 takes the query itself on insert.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign cell_valid[i] = entry_count > CNT_W'(i);
    psdf_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .entry_valid (cell_valid[i]),
      .ctl         (ctl),
      .query       (query),
      .left_entry  ((i == 0) ? query : cell_entry[(i == 0) ? 0 : i - 1]),
      .entry       (cell_entry[i]),
      .hit         (cell_hit[i]),
      .hit_data    (cell_data[i])
    );
  end

  // Addresses in the table are unique, so at most one cell hits and an OR merges the row.
  always_comb begin
    merge_found = 1'b0;
    merge_data  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      merge_found = merge_found | cell_hit[i];
      merge_data  = merge_data | cell_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_GATHER) begin
      found      <= merge_found;
      found_data <= merge_data;
    end
  end

  assign table_full = entry_count == CNT_W'(TABLE_DEPTH);

  psdf_decide u_decide (
    .own_address   (own_address),
    .seq_window    (seq_window),
    .timeout_ticks (timeout_ticks),
    .query         (query),
    .found         (found),
    .found_data    (found_data),
    .table_full    (table_full),
    .is_new        (dec_is_new),
    .status        (dec_status),
    .do_update     (dec_update),
    .do_insert     (dec_insert)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and cell commands.
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctl        = '0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        ctl.lookup = 1'b1;
        state_next = S_GATHER;
      end
      S_GATHER: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (out_free) begin
          out_load   = 1'b1;
          ctl.update = dec_update;
          ctl.shift  = dec_insert;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Entry count grows by one on every insert.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ctl.shift) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0000, dec_status, dec_is_new};
    end
  end

endmodule

FILE: sv/psdf_checker.sv
// Port checker for the sequence dedup filter and its bind to the top level.
`include "assert_macros.svh"

module psdf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [psdf_pkg::M_DATA_W-1:0] m_tdata
);
  import psdf_pkg::*;

  // The flag and the status code of a result must agree.
  `ASSERT_CLK(a_flag_matches_status, m_tvalid |-> (m_tdata[0] == ((m_tdata[3:1] != ST_DUPLICATE) && (m_tdata[3:1] != ST_OWN))), "is_new disagrees with status")

  // Only one beat is in flight: input is refused right after a beat is taken.
  `ASSERT_CLK(a_single_item, (s_tvalid && s_tready) |=> !s_tready, "second beat accepted while busy")

  // A result appears only after the lookup steps, never straight from idle.
  `ASSERT_CLK(a_result_after_work, $rose(m_tvalid) |-> !$past(s_tready), "result without a lookup")

  // A stalled result holds its beat.
  `ASSERT_CLK(a_stall_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind per_source_sequence_dedup_filter psdf_checker u_psdf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/testbench.sv
// Self-checking testbench for the per-source sequence number duplicate filter.
`timescale 1ns / 100ps

module testbench;
  import psdf_pkg::*;

  localparam int unsigned DEPTH = DEF_TABLE_DEPTH;
  localparam int POOL_N = 96;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One packet header as it travels in s_tdata, origin address in the low bits.
  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] addr;
  } packet_t;

  // Verdict for one packet.
  typedef struct packed {
    logic         is_new;
    psdf_status_t status;
  } verdict_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: a packet with its verdict, or a register write.
  typedef struct {
    row_kind_t         kind;
    psdf_reg_t         reg_sel;
    logic [CFG_W-1:0]  value;
    packet_t           pkt;
    verdict_t          want;
  } row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  // Shadow of the configuration and of the source table.
  logic [ADDR_W-1:0] own_addr;
  logic [SEQ_W-1:0]  seq_window;
  logic [TIME_W-1:0] timeout_ticks;
  int                src_count;
  logic [ADDR_W-1:0] src_addr [DEPTH];
  logic [SEQ_W-1:0]  src_seq  [DEPTH];
  logic [TIME_W-1:0] src_time [DEPTH];

  verdict_t pending_verdicts [$];

  // Directed stimulus table.
  row_t dir_rows [$];

  // Hand-typed verdict that travels along with the current beat.
  logic     typed_on;
  verdict_t typed_verdict;

  int src_idle_pct;
  int snk_idle_pct;
  int hold_request;
  int hold_left;
  int error_count;
  int idle_cycles;

  // Address pool for well-formed per-source sequences.
  logic [ADDR_W-1:0] pool_addr [POOL_N];
  logic [SEQ_W-1:0]  pool_seq  [POOL_N];
  int                pool_used;
  logic [TIME_W-1:0] clock_now;

  per_source_sequence_dedup_filter #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decide a packet against the shadow table and apply the table update.
  function automatic verdict_t filter_packet(input packet_t p);
    verdict_t          v;
    logic [TIME_W-1:0] age;
    logic [8:0]        advance;
    int                hit;
    hit = -1;
    v.is_new = 1'b0;
    v.status = ST_DUPLICATE;
    if (p.addr == own_addr) begin
      v.status = ST_OWN;
    end else begin
      for (int i = 0; i < src_count; i++)
        if (hit < 0 && src_addr[i] == p.addr) hit = i;
      if (hit >= 0) begin
        age = p.tstamp - src_time[hit];
        advance = 9'(8'(p.seq - src_seq[hit]));
        // An equal sequence counts as a full turn of the counter.
        if (advance == 9'd0) advance = 9'd256;
        if (age >= timeout_ticks || advance < {1'b0, seq_window}) begin
          src_seq[hit] = p.seq;
          src_time[hit] = p.tstamp;
          v.is_new = 1'b1;
          v.status = ST_KNOWN;
        end
      end else begin
        v.is_new = 1'b1;
        if (src_count < DEPTH) begin
          src_addr[src_count] = p.addr;
          src_seq[src_count] = p.seq;
          src_time[src_count] = p.tstamp;
          src_count++;
          v.status = ST_INSERTED;
        end else begin
          v.status = ST_FULL;
        end
      end
    end
    return v;
  endfunction

  function automatic row_t item_row(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq,
                                    input logic [TIME_W-1:0] t, input logic is_new,
                                    input psdf_status_t st);
    row_t r;
    r.kind = ROW_ITEM;
    r.reg_sel = REG_OWN_ADDRESS;
    r.value = '0;
    r.pkt = '{tstamp: t, seq: seq, addr: addr};
    r.want = '{is_new: is_new, status: st};
    return r;
  endfunction

  function automatic row_t cfg_row(input psdf_reg_t sel, input logic [CFG_W-1:0] value);
    row_t r;
    r.kind = ROW_CFG;
    r.reg_sel = sel;
    r.value = value;
    r.pkt = '0;
    r.want = '{is_new: 1'b0, status: ST_KNOWN};
    return r;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(input row_t r);
    dir_rows = {dir_rows, r};
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Offer one beat; valid drops only when a gap is taken before it.
  task automatic offer_packet(input packet_t p, input logic typed, input verdict_t tv);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_tdata <= p;
    typed_on <= typed;
    typed_verdict <= tv;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Write a register once the filter has drained.
  task automatic write_reg(input psdf_reg_t sel, input logic [CFG_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_OWN_ADDRESS:   own_addr = value[ADDR_W-1:0];
      REG_SEQ_WINDOW:    seq_window = value[SEQ_W-1:0];
      REG_TIMEOUT_TICKS: timeout_ticks = value[TIME_W-1:0];
      default: ;
    endcase
  endtask

  // One random phase: set all registers, then stream mostly well-formed traffic.
  task automatic run_phase(input int n_items, input logic [ADDR_W-1:0] own,
                           input logic [SEQ_W-1:0] win, input logic [TIME_W-1:0] tmo,
                           input int step_max, input int src_pct, input int snk_pct,
                           input int hold);
    packet_t  p;
    verdict_t none;
    int       pick;
    int       k;
    none = '{is_new: 1'b0, status: ST_KNOWN};
    write_reg(REG_OWN_ADDRESS, CFG_W'(own));
    write_reg(REG_SEQ_WINDOW, CFG_W'(win));
    write_reg(REG_TIMEOUT_TICKS, tmo);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    hold_request = hold;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      // Time moves forward, now and then by a whole timeout.
      if ($urandom_range(0, 9) == 0) clock_now = clock_now + timeout_ticks;
      else clock_now = clock_now + TIME_W'($urandom_range(0, step_max));
      p.tstamp = clock_now;
      if (pick < 6) begin
        p.addr = own_addr;
        p.seq = SEQ_W'($urandom);
      end else if (pick < 16) begin
        // Noise: any source, any sequence, sometimes any time.
        p.addr = $urandom;
        p.seq = SEQ_W'($urandom);
        if ($urandom_range(0, 2) == 0) p.tstamp = rand_time();
      end else begin
        if (pool_used == 0 || (pool_used < POOL_N && $urandom_range(0, 99) < 18)) begin
          k = pool_used;
          pool_used++;
        end else begin
          k = $urandom_range(0, pool_used - 1);
        end
        p.addr = pool_addr[k];
        pick = $urandom_range(0, 99);
        if (pick < 70) p.seq = pool_seq[k] + SEQ_W'($urandom_range(1, int'(seq_window) + 2));
        else if (pick < 80) p.seq = pool_seq[k];
        else p.seq = SEQ_W'($urandom);
        pool_seq[k] = p.seq;
      end
      offer_packet(p, 1'b0, none);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Predict the verdict of every accepted input beat.
  always @(posedge clk) begin : input_monitor
    verdict_t v;
    if (!rst && s_tvalid && s_tready) begin
      v = filter_packet(packet_t'(s_tdata));
      if (typed_on) v = typed_verdict;
      pending_verdicts = {pending_verdicts, v};
    end
  end

  // Compare every accepted result beat with the oldest expected verdict.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with no packet waiting: m_tdata=%h", m_tdata);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[0] !== want.is_new) begin
          $error("is_new: expected %0d, actual %0d", want.is_new, m_tdata[0]);
          error_count++;
        end
        if (m_tdata[3:1] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[3:1]);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no beat and no write goes through.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_OWN_ADDRESS;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    typed_on = 1'b0;
    typed_verdict = '{is_new: 1'b0, status: ST_KNOWN};
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 0;
    hold_left = 0;
    error_count = 0;
    idle_cycles = 0;
    own_addr = RST_OWN_ADDRESS;
    seq_window = RST_SEQ_WINDOW;
    timeout_ticks = RST_TIMEOUT_TICKS;
    src_count = 0;
    pool_used = 0;
    clock_now = '0;
    for (int i = 0; i < POOL_N; i++) begin
      pool_addr[i] = $urandom;
      pool_seq[i] = SEQ_W'($urandom);
    end

    // Reset values first, then the register extremes one by one.
    add_row(item_row(32'h0, 8'h00, 48'd0, 1'b0, ST_OWN));
    add_row(item_row(32'hFFFF_FFFF, 8'h00, 48'd0, 1'b1, ST_INSERTED));
    // An equal sequence is a duplicate.
    add_row(item_row(32'hFFFF_FFFF, 8'h00, 48'd5, 1'b0, ST_DUPLICATE));
    add_row(item_row(32'hFFFF_FFFF, 8'h09, 48'd6, 1'b1, ST_KNOWN));
    // Advance equal to the window, then the largest advance.
    add_row(item_row(32'hFFFF_FFFF, 8'h13, 48'd7, 1'b0, ST_DUPLICATE));
    add_row(item_row(32'hFFFF_FFFF, 8'h08, 48'd8, 1'b0, ST_DUPLICATE));
    // Age exactly at the timeout.
    add_row(item_row(32'hFFFF_FFFF, 8'h08, 48'd1000006, 1'b1, ST_KNOWN));
    // Clock wraps between two packets of the same source.
    add_row(item_row(32'h1, 8'hFF, TIME_MAX, 1'b1, ST_INSERTED));
    add_row(item_row(32'h1, 8'h00, 48'd4, 1'b1, ST_KNOWN));
    add_row(cfg_row(REG_OWN_ADDRESS, 48'hFFFF_FFFF));
    add_row(item_row(32'hFFFF_FFFF, 8'hAA, 48'd0, 1'b0, ST_OWN));
    add_row(cfg_row(REG_SEQ_WINDOW, 48'd255));
    add_row(cfg_row(REG_TIMEOUT_TICKS, TIME_MAX));
    add_row(item_row(32'h1, 8'hFF, 48'd10, 1'b0, ST_DUPLICATE));
    add_row(item_row(32'h1, 8'hFE, 48'd11, 1'b1, ST_KNOWN));
    // Age of all ones meets the largest timeout.
    add_row(item_row(32'h1, 8'hFE, 48'd10, 1'b1, ST_KNOWN));
    // Zero window: only the timeout can accept a known source.
    add_row(cfg_row(REG_SEQ_WINDOW, 48'd0));
    add_row(item_row(32'h1, 8'hFF, 48'd12, 1'b0, ST_DUPLICATE));
    // Zero timeout accepts everything from a known source.
    add_row(cfg_row(REG_TIMEOUT_TICKS, 48'd0));
    add_row(item_row(32'h1, 8'hFF, 48'd12, 1'b1, ST_KNOWN));
    add_row(item_row(32'h5A5A_5A5A, 8'h80, 48'h8000_0000_0000, 1'b1, ST_INSERTED));

    repeat (8) @(negedge clk);
    rst = 1'b0;

    src_idle_pct = 26;
    snk_idle_pct = 52;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
      else offer_packet(dir_rows[i].pkt, 1'b1, dir_rows[i].want);
    end
    clock_now = 48'd1_000_000_000;

    // Sender idles less than the receiver first, then the reverse, then neither idles.
    run_phase(75, $urandom, 8'd10, 48'd100000, 30000, 26, 52, 0);
    run_phase(75, 32'hFFFF_FFFF, 8'd255, 48'd0, 1000, 26, 52, 300);
    run_phase(75, 32'h0, 8'd1, TIME_MAX, 50000, 52, 26, 0);
    run_phase(75, $urandom, SEQ_W'($urandom_range(1, 255)), TIME_W'($urandom_range(0, 200000)),
              40000, 52, 26, 0);
    clock_now = 48'hFFFF_FFF0_0000;
    run_phase(75, $urandom, 8'd128, 48'd1000000, 200000, 0, 0, 0);
    run_phase(75, $urandom, SEQ_W'($urandom_range(1, 255)), TIME_W'($urandom_range(0, 1 << 24)),
              1 << 20, 0, 0, 0);

    // Drain and let any stray beat show up.
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_verdicts.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: per_source_sequence_dedup_filter.f
+incdir+sv
sv/psdf_pkg.sv
sv/psdf_cell.sv
sv/psdf_decide.sv
sv/per_source_sequence_dedup_filter.sv
sv/psdf_checker.sv
tb/testbench.sv
